FILE: hw/rtl/lobm_pkg.sv
package lobm_pkg;

  localparam int BOOK_DEPTH  = 32;
  localparam int NUM_SYMBOLS = 4;
  localparam int PRICE_BITS  = 16;
  localparam int QTY_BITS    = 24;
  localparam int SYM_BITS    = 2;
  localparam int SYM_IDX_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CNT_W       = $clog2(BOOK_DEPTH + 1);

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INS,
    OP_POP,
    OP_DEC
  } cell_op_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } entry_t;

  typedef struct packed {
    cell_op_t              op;
    logic                  sell;
    logic [SYM_IDX_W-1:0]  sym;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;   // new quantity on insert, amount on decrement
  } cell_cmd_t;

  typedef struct packed {
    logic [SYM_BITS-1:0]   symbol_id;
    logic                  side;
    logic [PRICE_BITS-1:0] price_ticks;
    logic [QTY_BITS-1:0]   quantity;
  } order_t;

  typedef struct packed {
    logic                  kind;
    logic [QTY_BITS-1:0]   trade_quantity;
    logic [PRICE_BITS-1:0] trade_price;
    logic                  book_full;
    logic [QTY_BITS-1:0]   best_bid_qty;
    logic [QTY_BITS-1:0]   best_ask_qty;
    logic                  last;
  } result_t;

endpackage

FILE: hw/rtl/lobm_cell.sv
module lobm_cell (
  input  logic               clk,
  input  lobm_pkg::cell_cmd_t cmd,
  input  logic               valid,
  input  logic               head,
  input  logic               left_keep,
  input  lobm_pkg::entry_t   left_ent,
  input  lobm_pkg::entry_t   right_ent,
  output lobm_pkg::entry_t   ent,
  output logic               keep
);

  // One slot of this book position per symbol.
  lobm_pkg::entry_t slots [lobm_pkg::NUM_SYMBOLS];
  lobm_pkg::entry_t slot_next;

  assign ent  = slots[cmd.sym];
  // Entry stays ahead of the new order: better or equal price.
  assign keep = valid && (cmd.sell ? (ent.price <= cmd.price) : (ent.price >= cmd.price));

  always_comb begin
    slot_next = ent;
    case (cmd.op)
      lobm_pkg::OP_INS: begin
        if (!keep) begin
          if (left_keep) begin
            slot_next.price = cmd.price;
            slot_next.qty   = cmd.qty;
          end else begin
            slot_next = left_ent;
          end
        end
      end
      lobm_pkg::OP_POP: slot_next = right_ent;
      // Only the top of book is partly filled.
      lobm_pkg::OP_DEC: begin
        if (head) slot_next.qty = ent.qty - cmd.qty;
      end
      default: slot_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op != lobm_pkg::OP_NOP) begin
      slots[cmd.sym] <= slot_next;
    end
  end

endmodule

FILE: hw/rtl/limit_order_book_matcher.sv
// Price-priority limit order book matcher, four symbols, two books each.
// Request channel: order (symbol_id, side, price_ticks, quantity) is taken at
// a rising edge with start high and busy low. Busy stays high while the order
// is worked on.
// Result channel: each report is marked by result_valid high for exactly one
// cycle. Trade reports come first, then one end report with last set.
// The receiver cannot stall the block; it must take every report.
// Each book is a row of cells, one per price level, holding that level for
// every symbol. On insert, every cell compares its price to the
// order and either keeps, takes the order, or takes its left neighbor.
// A match pops or decrements the top cell, one trade per cycle, the whole row
// shifting left by one on a pop.
// Steps per order: insert, one step per trade, one for the failed cross test,
// then the end report; the next request can be taken at the edge that ends the
// cycle the end report is shown. Zero quantity, full book and bad symbol orders
// skip the match steps.
// Reset clears the entry counts (empty books) and the sequencer; cell
// contents are not cleared and are only read below the counts.
module limit_order_book_matcher (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lobm_pkg::order_t  order,
  output logic              busy,
  output logic              result_valid,
  output lobm_pkg::result_t result
);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_MATCH, S_END} state_t;

  localparam int D = lobm_pkg::BOOK_DEPTH;

  state_t                          state;
  lobm_pkg::order_t                ord;
  logic                            full;
  logic [lobm_pkg::CNT_W-1:0]      tcount;
  logic [lobm_pkg::CNT_W-1:0]      counts [lobm_pkg::NUM_SYMBOLS][2];

  lobm_pkg::cell_cmd_t             buy_cmd, sell_cmd;
  lobm_pkg::entry_t                buy_ent  [D];
  lobm_pkg::entry_t                sell_ent [D];
  logic [D-1:0]                    buy_keep, sell_keep, buy_valid, sell_valid;

  logic [lobm_pkg::SYM_IDX_W-1:0]  sym;
  logic                            in_range;
  logic [lobm_pkg::CNT_W-1:0]      nb, ns, nm;
  logic                            ins_ok, go;
  logic [lobm_pkg::QTY_BITS-1:0]   m;
  logic                            pop_buy, pop_sell;

  assign sym      = ord.symbol_id[lobm_pkg::SYM_IDX_W-1:0];
  assign in_range = int'(ord.symbol_id) < lobm_pkg::NUM_SYMBOLS;
  assign nb       = counts[sym][0];
  assign ns       = counts[sym][1];
  assign nm       = ord.side ? ns : nb;
  assign ins_ok   = in_range && (ord.quantity != '0) && (nm < lobm_pkg::CNT_W'(D));

  // Top of book crossing test and fill size.
  assign go = (nb != '0) && (ns != '0) && (buy_ent[0].price >= sell_ent[0].price)
              && (tcount < lobm_pkg::CNT_W'(D));
  assign m  = (buy_ent[0].qty < sell_ent[0].qty) ? buy_ent[0].qty : sell_ent[0].qty;
  assign pop_buy  = (buy_ent[0].qty == m);
  assign pop_sell = (sell_ent[0].qty == m);

  // Cell commands for both rows.
  always_comb begin
    buy_cmd.op     = lobm_pkg::OP_NOP;
    buy_cmd.sell   = lobm_pkg::SIDE_BUY;
    buy_cmd.sym    = sym;
    buy_cmd.price  = ord.price_ticks;
    buy_cmd.qty    = ord.quantity;
    sell_cmd       = buy_cmd;
    sell_cmd.sell  = lobm_pkg::SIDE_SELL;
    case (state)
      S_INS: begin
        if (ins_ok) begin
          if (ord.side == lobm_pkg::SIDE_SELL) sell_cmd.op = lobm_pkg::OP_INS;
          else                                 buy_cmd.op  = lobm_pkg::OP_INS;
        end
      end
      S_MATCH: begin
        if (go) begin
          buy_cmd.qty  = m;
          sell_cmd.qty = m;
          buy_cmd.op   = pop_buy  ? lobm_pkg::OP_POP : lobm_pkg::OP_DEC;
          sell_cmd.op  = pop_sell ? lobm_pkg::OP_POP : lobm_pkg::OP_DEC;
        end
      end
      default: ;
    endcase
  end

  // Two rows of cells; the last cell's right neighbor is itself, and after a pop that slot lies past the count.
  for (genvar i = 0; i < D; i++) begin : g_row
    assign buy_valid[i]  = lobm_pkg::CNT_W'(i) < nb;
    assign sell_valid[i] = lobm_pkg::CNT_W'(i) < ns;

    lobm_cell u_buy (
      .clk       (clk),
      .cmd       (buy_cmd),
      .valid     (buy_valid[i]),
      .head      ((i == 0) ? 1'b1 : 1'b0),
      .left_keep ((i == 0) ? 1'b1 : buy_keep[(i == 0) ? 0 : i-1]),
      .left_ent  (buy_ent[(i == 0) ? 0 : i-1]),
      .right_ent (buy_ent[(i == D-1) ? i : i+1]),
      .ent       (buy_ent[i]),
      .keep      (buy_keep[i])
    );

    lobm_cell u_sell (
      .clk       (clk),
      .cmd       (sell_cmd),
      .valid     (sell_valid[i]),
      .head      ((i == 0) ? 1'b1 : 1'b0),
      .left_keep ((i == 0) ? 1'b1 : sell_keep[(i == 0) ? 0 : i-1]),
      .left_ent  (sell_ent[(i == 0) ? 0 : i-1]),
      .right_ent (sell_ent[(i == D-1) ? i : i+1]),
      .ent       (sell_ent[i]),
      .keep      (sell_keep[i])
    );
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      tcount       <= '0;
      full         <= 1'b0;
      for (int s = 0; s < lobm_pkg::NUM_SYMBOLS; s++) begin
        counts[s][0] <= '0;
        counts[s][1] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            ord    <= order;
            tcount <= '0;
            state  <= S_INS;
          end
        end
        S_INS: begin
          full <= in_range && (ord.quantity != '0) && !ins_ok;
          if (ins_ok) begin
            counts[sym][ord.side] <= nm + 1'b1;
            state <= S_MATCH;
          end else begin
            state <= S_END;
          end
        end
        S_MATCH: begin
          if (go) begin
            result_valid <= 1'b1;
            result       <= '{kind: lobm_pkg::KIND_TRADE, trade_quantity: m,
                              trade_price: sell_ent[0].price, book_full: 1'b0,
                              best_bid_qty: '0, best_ask_qty: '0, last: 1'b0};
            tcount       <= tcount + 1'b1;
            if (pop_buy)  counts[sym][0] <= nb - 1'b1;
            if (pop_sell) counts[sym][1] <= ns - 1'b1;
          end else begin
            state <= S_END;
          end
        end
        S_END: begin
          result_valid <= 1'b1;
          result       <= '{kind: lobm_pkg::KIND_END, trade_quantity: '0,
                            trade_price: '0, book_full: full,
                            best_bid_qty: (in_range && nb != '0) ? buy_ent[0].qty : '0,
                            best_ask_qty: (in_range && ns != '0) ? sell_ent[0].qty : '0,
                            last: 1'b1};
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lobm_checker.sv
module lobm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input lobm_pkg::result_t result
);

  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy) else $error("end report while busy");

  a_trade_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy) else $error("trade report after end");

  a_fell_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid && result.last) else $error("busy fell without end");

  a_trade_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == lobm_pkg::KIND_TRADE |-> !result.book_full
      && result.trade_quantity != '0) else $error("bad trade report");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
